// ===== rtl/core/csrgb_pkg.sv =====
// Shared constants and types of the color space to RGB converter.
// Holds the mode codes, the fixed-point coefficients and the divider settings.
// Depends on nothing; every other file of the block takes names from here.
`timescale 1ns / 1ps

package csrgb_pkg;

    // Mode register codes. The unused code behaves like pass-through.
    localparam logic [1:0] MODE_RGB = 2'd0;
    localparam logic [1:0] MODE_YCC = 2'd1;
    localparam logic [1:0] MODE_HSV = 2'd2;

    localparam int CHAN_W = 8;
    localparam int MODE_W = 2;

    // YCbCr sums are signed Q16 values; 26 bits hold the widest case.
    localparam int SUM_W = 26;
    localparam logic signed [SUM_W-1:0] K_CR_R = 26'sd91881;
    localparam logic signed [SUM_W-1:0] K_CB_G = 26'sd22553;
    localparam logic signed [SUM_W-1:0] K_CR_G = 26'sd46802;
    localparam logic signed [SUM_W-1:0] K_CB_B = 26'sd116130;

    // HSV constants.
    localparam int HUE_SPAN   = 255;
    localparam int SECTORS    = 6;
    localparam int SECTOR_W   = 3;
    localparam int FULL_SCALE = 65025;
    localparam int FACTOR_W   = 16;

    // Rounded division by 255 uses (2n + 255) / 510, by 65025 uses
    // (2n + 65025) / 130050. The shifts keep every numerator below 2^SHIFT.
    localparam int P_NUM_W = 17;
    localparam int P_DEN   = 510;
    localparam int P_SHIFT = 24;
    localparam int Q_NUM_W = 25;
    localparam int Q_DEN   = 130050;
    localparam int Q_SHIFT = 32;

    // Load enables of the two register stages inside a constant divider.
    typedef struct packed {
        logic en_est;
        logic en_fix;
    } csrgb_div_ctl_t;

endpackage

// ===== rtl/core/csrgb_in_if.sv =====
// Input pixel channel: valid/ready handshake and three 8-bit channels.
// Depends on csrgb_pkg for the channel width.
`timescale 1ns / 1ps

interface csrgb_in_if;
    logic                            valid;
    logic                            ready;
    logic [csrgb_pkg::CHAN_W-1:0]    chan_a;
    logic [csrgb_pkg::CHAN_W-1:0]    chan_b;
    logic [csrgb_pkg::CHAN_W-1:0]    chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

// ===== rtl/core/csrgb_out_if.sv =====
// Output pixel channel: valid/ready handshake and 8-bit red, green, blue.
// Depends on csrgb_pkg for the channel width.
`timescale 1ns / 1ps

interface csrgb_out_if;
    logic                            valid;
    logic                            ready;
    logic [csrgb_pkg::CHAN_W-1:0]    red;
    logic [csrgb_pkg::CHAN_W-1:0]    green;
    logic [csrgb_pkg::CHAN_W-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/color_space_to_rgb_unit.sv =====
// Top level of the color space to RGB converter: pass-through, YCbCr or HSV.
// Depends on csrgb_pkg, csrgb_in_if, csrgb_out_if and csrgb_const_div.
//
//   channel   direction  payload                 handshake
//   pix_in    in         chan_a, chan_b, chan_c  valid / ready
//   pix_out   out        red, green, blue        valid / ready
//   mode      in         mode_wdata (2 bits)     mode_we, no wait
//
// One pixel per clock while the output is not stalled; each pixel passes through
// the seven register stages (the two reciprocal divider stages among them).
// Every stage holds its own valid bit and loads when it is empty or the next
// stage moves on, so a stalled output fills the bubbles before ready drops.
// Reset clears the valid bits and sets the mode to pass-through.
`timescale 1ns / 1ps

module color_space_to_rgb_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mode_we,
    input  logic [csrgb_pkg::MODE_W-1:0]  mode_wdata,
    csrgb_in_if.sink                      pix_in,
    csrgb_out_if.source                   pix_out
);

    localparam int CHAN_W   = csrgb_pkg::CHAN_W;
    localparam int SUM_W    = csrgb_pkg::SUM_W;
    localparam int SECTOR_W = csrgb_pkg::SECTOR_W;
    localparam int FACTOR_W = csrgb_pkg::FACTOR_W;
    localparam int P_NUM_W  = csrgb_pkg::P_NUM_W;
    localparam int Q_NUM_W  = csrgb_pkg::Q_NUM_W;
    localparam int HUE6_W   = CHAN_W + 3;
    localparam int PIX_W    = 3 * CHAN_W;

    logic [csrgb_pkg::MODE_W-1:0] mode_reg;

    // Stage enables and valid bits.
    logic en1, en2, en3, en4, en5, en6, en7;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;

    // Stage 1: captured pixel.
    logic [CHAN_W-1:0]            s1_a_reg, s1_b_reg, s1_c_reg;
    logic [csrgb_pkg::MODE_W-1:0] s1_mode_reg;

    // Stage 2: YCbCr sums, HSV sector and remainder.
    logic signed [SUM_W-1:0]      base, db_ext, dr_ext;
    logic signed [CHAN_W:0]       db, dr;
    logic [HUE6_W-1:0]            hue6;
    logic [HUE6_W-1:0]            rem_wide;
    logic signed [SUM_W-1:0]      s2_sum_r_next, s2_sum_g_next, s2_sum_b_next;
    logic signed [SUM_W-1:0]      s2_sum_r_reg, s2_sum_g_reg, s2_sum_b_reg;
    logic [SECTOR_W-1:0]          s2_sector_next, s2_sector_reg;
    logic [CHAN_W-1:0]            s2_rem_next, s2_rem_reg;
    logic [PIX_W-1:0]             s2_pix_reg;
    logic [csrgb_pkg::MODE_W-1:0] s2_mode_reg;

    // Stage 3: clamped direct result and HSV factors.
    logic [CHAN_W-1:0]            clamp_r, clamp_g, clamp_b;
    logic [CHAN_W-1:0]            s2_s, s2_v;
    logic [PIX_W-1:0]             s3_direct_next, s3_direct_reg;
    logic [CHAN_W-1:0]            s3_fp_next, s3_fp_reg;
    logic [FACTOR_W-1:0]          s3_fq_next, s3_fq_reg;
    logic [FACTOR_W-1:0]          s3_ft_next, s3_ft_reg;
    logic [CHAN_W-1:0]            s3_v_reg;
    logic [SECTOR_W-1:0]          s3_sector_reg;
    logic                         s3_hsv_reg;

    // Stage 4: rounding numerators.
    logic [FACTOR_W-1:0]          prod_p;
    logic [Q_NUM_W-2:0]           prod_q, prod_t;
    logic [P_NUM_W-1:0]           s4_np_next, s4_np_reg;
    logic [Q_NUM_W-1:0]           s4_nq_next, s4_nq_reg;
    logic [Q_NUM_W-1:0]           s4_nt_next, s4_nt_reg;
    logic [PIX_W-1:0]             s4_direct_reg;
    logic [CHAN_W-1:0]            s4_v_reg;
    logic [SECTOR_W-1:0]          s4_sector_reg;
    logic                         s4_hsv_reg;

    // Stages 5 and 6: side data next to the dividers.
    logic [PIX_W-1:0]             s5_direct_reg, s6_direct_reg;
    logic [CHAN_W-1:0]            s5_v_reg, s6_v_reg;
    logic [SECTOR_W-1:0]          s5_sector_reg, s6_sector_reg;
    logic                         s5_hsv_reg, s6_hsv_reg;
    logic [CHAN_W-1:0]            p_val, q_val, t_val;
    csrgb_pkg::csrgb_div_ctl_t    div_ctl;

    // Stage 7: output register.
    logic [CHAN_W-1:0]            s7_red_next, s7_green_next, s7_blue_next;
    logic [CHAN_W-1:0]            s7_red_reg, s7_green_reg, s7_blue_reg;

    always_comb
    begin
        en7 = !s7_valid_reg || pix_out.ready;
        en6 = !s6_valid_reg || en7;
        en5 = !s5_valid_reg || en6;
        en4 = !s4_valid_reg || en5;
        en3 = !s3_valid_reg || en4;
        en2 = !s2_valid_reg || en3;
        en1 = !s1_valid_reg || en2;
    end

    assign pix_in.ready   = en1;
    assign div_ctl.en_est = en5;
    assign div_ctl.en_fix = en6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= csrgb_pkg::MODE_RGB;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end
            if (en1) s1_valid_reg <= pix_in.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
            if (en7) s7_valid_reg <= s6_valid_reg;
        end
    end

    // Stage 2 logic: Q16 sums with the rounding half already added, and the
    // hue sector found by comparing 6h against each multiple of 255.
    always_comb
    begin
        base   = $signed({2'b00, s1_a_reg, 16'h8000});
        db     = $signed({1'b0, s1_b_reg}) - 9'sd128;
        dr     = $signed({1'b0, s1_c_reg}) - 9'sd128;
        db_ext = SUM_W'(db);
        dr_ext = SUM_W'(dr);
        s2_sum_r_next = base + csrgb_pkg::K_CR_R * dr_ext;
        s2_sum_g_next = base - csrgb_pkg::K_CB_G * db_ext - csrgb_pkg::K_CR_G * dr_ext;
        s2_sum_b_next = base + csrgb_pkg::K_CB_B * db_ext;

        hue6 = HUE6_W'({s1_a_reg, 2'b00}) + HUE6_W'({s1_a_reg, 1'b0});
        s2_sector_next = '0;
        for (int k = 1; k <= csrgb_pkg::SECTORS; k++)
        begin
            s2_sector_next = s2_sector_next
                           + SECTOR_W'(hue6 >= HUE6_W'(csrgb_pkg::HUE_SPAN * k));
        end
        rem_wide    = hue6 - HUE6_W'(s2_sector_next) * HUE6_W'(csrgb_pkg::HUE_SPAN);
        s2_rem_next = rem_wide[CHAN_W-1:0];
    end

    // Stage 3 logic: clamp the sums, form the three HSV factors.
    // A zero saturation gives full factors, so p, q and t all come out as v.
    always_comb
    begin
        clamp_r = s2_sum_r_reg[SUM_W-1] ? '0 :
                  s2_sum_r_reg[SUM_W-2] ? '1 : s2_sum_r_reg[23:16];
        clamp_g = s2_sum_g_reg[SUM_W-1] ? '0 :
                  s2_sum_g_reg[SUM_W-2] ? '1 : s2_sum_g_reg[23:16];
        clamp_b = s2_sum_b_reg[SUM_W-1] ? '0 :
                  s2_sum_b_reg[SUM_W-2] ? '1 : s2_sum_b_reg[23:16];
        if (s2_mode_reg == csrgb_pkg::MODE_YCC)
        begin
            s3_direct_next = {clamp_r, clamp_g, clamp_b};
        end
        else
        begin
            s3_direct_next = s2_pix_reg;
        end

        s2_s       = s2_pix_reg[CHAN_W +: CHAN_W];
        s2_v       = s2_pix_reg[0 +: CHAN_W];
        s3_fp_next = CHAN_W'(csrgb_pkg::HUE_SPAN) - s2_s;
        s3_fq_next = FACTOR_W'(csrgb_pkg::FULL_SCALE)
                   - FACTOR_W'(s2_rem_reg) * FACTOR_W'(s2_s);
        s3_ft_next = FACTOR_W'(csrgb_pkg::FULL_SCALE)
                   - FACTOR_W'(CHAN_W'(csrgb_pkg::HUE_SPAN) - s2_rem_reg)
                     * FACTOR_W'(s2_s);
    end

    // Stage 4 logic: numerators 2*v*f + den/2 for round half up.
    always_comb
    begin
        prod_p     = FACTOR_W'(s3_v_reg) * FACTOR_W'(s3_fp_reg);
        prod_q     = (Q_NUM_W-1)'(s3_v_reg) * (Q_NUM_W-1)'(s3_fq_reg);
        prod_t     = (Q_NUM_W-1)'(s3_v_reg) * (Q_NUM_W-1)'(s3_ft_reg);
        s4_np_next = {prod_p, 1'b0} + P_NUM_W'(csrgb_pkg::HUE_SPAN);
        s4_nq_next = {prod_q, 1'b0} + Q_NUM_W'(csrgb_pkg::FULL_SCALE);
        s4_nt_next = {prod_t, 1'b0} + Q_NUM_W'(csrgb_pkg::FULL_SCALE);
    end

    csrgb_const_div #(
        .NUM_W (P_NUM_W),
        .Q_W   (CHAN_W),
        .DEN   (csrgb_pkg::P_DEN),
        .SHIFT (csrgb_pkg::P_SHIFT)
    ) u_div_p (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (s4_np_reg),
        .quot (p_val)
    );

    csrgb_const_div #(
        .NUM_W (Q_NUM_W),
        .Q_W   (CHAN_W),
        .DEN   (csrgb_pkg::Q_DEN),
        .SHIFT (csrgb_pkg::Q_SHIFT)
    ) u_div_q (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (s4_nq_reg),
        .quot (q_val)
    );

    csrgb_const_div #(
        .NUM_W (Q_NUM_W),
        .Q_W   (CHAN_W),
        .DEN   (csrgb_pkg::Q_DEN),
        .SHIFT (csrgb_pkg::Q_SHIFT)
    ) u_div_t (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (s4_nt_reg),
        .quot (t_val)
    );

    // Stage 7 logic: arrange v, p, q, t by sector. Hue 255 lands in sector
    // six and takes the last sector's arrangement through the default arm.
    always_comb
    begin
        if (!s6_hsv_reg)
        begin
            {s7_red_next, s7_green_next, s7_blue_next} = s6_direct_reg;
        end
        else
        begin
            case (s6_sector_reg)
                3'd0:    {s7_red_next, s7_green_next, s7_blue_next} = {s6_v_reg, t_val, p_val};
                3'd1:    {s7_red_next, s7_green_next, s7_blue_next} = {q_val, s6_v_reg, p_val};
                3'd2:    {s7_red_next, s7_green_next, s7_blue_next} = {p_val, s6_v_reg, t_val};
                3'd3:    {s7_red_next, s7_green_next, s7_blue_next} = {p_val, q_val, s6_v_reg};
                3'd4:    {s7_red_next, s7_green_next, s7_blue_next} = {t_val, p_val, s6_v_reg};
                default: {s7_red_next, s7_green_next, s7_blue_next} = {s6_v_reg, p_val, q_val};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_a_reg    <= pix_in.chan_a;
            s1_b_reg    <= pix_in.chan_b;
            s1_c_reg    <= pix_in.chan_c;
            s1_mode_reg <= mode_reg;
        end
        if (en2)
        begin
            s2_sum_r_reg  <= s2_sum_r_next;
            s2_sum_g_reg  <= s2_sum_g_next;
            s2_sum_b_reg  <= s2_sum_b_next;
            s2_sector_reg <= s2_sector_next;
            s2_rem_reg    <= s2_rem_next;
            s2_pix_reg    <= {s1_a_reg, s1_b_reg, s1_c_reg};
            s2_mode_reg   <= s1_mode_reg;
        end
        if (en3)
        begin
            s3_direct_reg <= s3_direct_next;
            s3_fp_reg     <= s3_fp_next;
            s3_fq_reg     <= s3_fq_next;
            s3_ft_reg     <= s3_ft_next;
            s3_v_reg      <= s2_v;
            s3_sector_reg <= s2_sector_reg;
            s3_hsv_reg    <= (s2_mode_reg == csrgb_pkg::MODE_HSV);
        end
        if (en4)
        begin
            s4_np_reg     <= s4_np_next;
            s4_nq_reg     <= s4_nq_next;
            s4_nt_reg     <= s4_nt_next;
            s4_direct_reg <= s3_direct_reg;
            s4_v_reg      <= s3_v_reg;
            s4_sector_reg <= s3_sector_reg;
            s4_hsv_reg    <= s3_hsv_reg;
        end
        if (en5)
        begin
            s5_direct_reg <= s4_direct_reg;
            s5_v_reg      <= s4_v_reg;
            s5_sector_reg <= s4_sector_reg;
            s5_hsv_reg    <= s4_hsv_reg;
        end
        if (en6)
        begin
            s6_direct_reg <= s5_direct_reg;
            s6_v_reg      <= s5_v_reg;
            s6_sector_reg <= s5_sector_reg;
            s6_hsv_reg    <= s5_hsv_reg;
        end
        if (en7)
        begin
            s7_red_reg   <= s7_red_next;
            s7_green_reg <= s7_green_next;
            s7_blue_reg  <= s7_blue_next;
        end
    end

    assign pix_out.valid = s7_valid_reg;
    assign pix_out.red   = s7_red_reg;
    assign pix_out.green = s7_green_reg;
    assign pix_out.blue  = s7_blue_reg;

endmodule

// ===== rtl/core/csrgb_const_div.sv =====
// Two-stage divider of an unsigned numerator by a constant.
// A reciprocal multiply gives an estimate, one compare and add corrects it.
// Depends on csrgb_pkg for the stage control struct and the default settings.
`timescale 1ns / 1ps

module csrgb_const_div #(
    parameter int NUM_W = csrgb_pkg::Q_NUM_W,
    parameter int Q_W   = csrgb_pkg::CHAN_W,
    parameter int DEN   = csrgb_pkg::Q_DEN,
    parameter int SHIFT = csrgb_pkg::Q_SHIFT
) (
    input  logic                       clk,
    input  csrgb_pkg::csrgb_div_ctl_t  ctl,
    input  logic [NUM_W-1:0]           num,
    output logic [Q_W-1:0]             quot
);

    localparam longint unsigned RECIP = (64'd1 << SHIFT) / DEN;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = NUM_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  back;
    logic [NUM_W-1:0]  rem;
    logic              fix;

    logic [Q_W-1:0]    est_reg;
    logic [Q_W-1:0]    est_next;
    logic [NUM_W-1:0]  num_reg;
    logic [Q_W-1:0]    quot_reg;
    logic [Q_W-1:0]    quot_next;

    // The estimate is never above the true quotient and at most one below,
    // because every numerator stays under 2^SHIFT.
    always_comb
    begin
        prod     = PROD_W'(num) * PROD_W'(RECIP_W'(RECIP));
        est_next = prod[SHIFT +: Q_W];
    end

    always_comb
    begin
        back      = NUM_W'(est_reg) * NUM_W'(DEN);
        rem       = num_reg - back;
        fix       = (rem >= NUM_W'(DEN));
        quot_next = est_reg + Q_W'(fix);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_est)
        begin
            est_reg <= est_next;
            num_reg <= num;
        end
        if (ctl.en_fix)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// ===== test/tb_color_space_to_rgb_unit.sv =====
// Self-checking testbench for color_space_to_rgb_unit: pass-through, YCbCr and HSV pixels.
// Depends on csrgb_pkg, csrgb_in_if, csrgb_out_if and the block itself.
// A scoreboard class predicts each RGB result and compares it with what leaves the block.
`timescale 1ns / 1ps

module tb_color_space_to_rgb_unit;

    localparam int CHAN_W = csrgb_pkg::CHAN_W;
    localparam int MODE_W = csrgb_pkg::MODE_W;

    // The fourth mode code has no name in the package; it behaves like pass-through.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DEPTH  = 7;
    localparam int PHASE_ITEMS = 240;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

    class pixel_scoreboard;
        rgb_pixel_t        pending_rgb[$];
        logic [MODE_W-1:0] mode;
        int                errors;

        function new();
            mode   = csrgb_pkg::MODE_RGB;
            errors = 0;
        endfunction

        function void set_mode(logic [MODE_W-1:0] m);
            mode = m;
        endfunction

        function logic [CHAN_W-1:0] clamp_q16(longint sum);
            longint whole;
            if (sum < 0)
                return 0;
            whole = sum >>> 16;
            return (whole > 255) ? 8'd255 : whole[CHAN_W-1:0];
        endfunction

        function rgb_pixel_t ycc_pixel(int y, int cb, int cr);
            rgb_pixel_t px;
            longint     base;
            longint     db;
            longint     dr;
            base     = longint'(y) * 65536 + 32768;
            db       = cb - 128;
            dr       = cr - 128;
            px.red   = clamp_q16(base + 91881 * dr);
            px.green = clamp_q16(base - 22553 * db - 46802 * dr);
            px.blue  = clamp_q16(base + 116130 * db);
            return px;
        endfunction

        function rgb_pixel_t hsv_pixel(int h, int s, int v);
            rgb_pixel_t px;
            int         sector;
            int         rem;
            int         p;
            int         q;
            int         t;
            if (s == 0)
            begin
                px.red   = CHAN_W'(v);
                px.green = CHAN_W'(v);
                px.blue  = CHAN_W'(v);
                return px;
            end
            sector = (6 * h) / 255;
            rem    = 6 * h - 255 * sector;
            p      = (2 * v * (255 - s) + 255) / 510;
            q      = (2 * v * (65025 - rem * s) + 65025) / 130050;
            t      = (2 * v * (65025 - (255 - rem) * s) + 65025) / 130050;
            // A hue of 255 lands in sector 6, which shares the last sector's mapping.
            case (sector)
                0:       px = {8'(v), 8'(t), 8'(p)};
                1:       px = {8'(q), 8'(v), 8'(p)};
                2:       px = {8'(p), 8'(v), 8'(t)};
                3:       px = {8'(p), 8'(q), 8'(v)};
                4:       px = {8'(t), 8'(p), 8'(v)};
                default: px = {8'(v), 8'(p), 8'(q)};
            endcase
            return px;
        endfunction

        function void note_request(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                   logic [CHAN_W-1:0] c);
            rgb_pixel_t px;
            case (mode)
                csrgb_pkg::MODE_YCC: px = ycc_pixel(a, b, c);
                csrgb_pkg::MODE_HSV: px = hsv_pixel(a, b, c);
                default:             px = {a, b, c};
            endcase
            pending_rgb.push_back(px);
        endfunction

        function void check_result(rgb_pixel_t got);
            rgb_pixel_t want;
            if (pending_rgb.size() == 0)
            begin
                $display("%0t: result with no request pending, actual %0d %0d %0d",
                         $time, got.red, got.green, got.blue);
                errors++;
                return;
            end
            want = pending_rgb.pop_front();
            if (got.red !== want.red)
            begin
                $display("%0t: red expected %0d, actual %0d", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $display("%0t: green expected %0d, actual %0d", $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $display("%0t: blue expected %0d, actual %0d", $time, want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              mode_we;
    logic [MODE_W-1:0] mode_wdata;
    bit                idle_on;
    int                cycle_count;
    int                stall_left;

    csrgb_in_if  pix_in_ch();
    csrgb_out_if pix_out_ch();

    pixel_scoreboard sb = new();

    color_space_to_rgb_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .pix_in     (pix_in_ch),
        .pix_out    (pix_out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("color_space_to_rgb_unit regression: fail");
            $finish;
        end
    end

    // Result side: random stall bursts on ready while idling is enabled.
    initial
    begin
        pix_out_ch.ready <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                pix_out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                pix_out_ch.ready <= 1'b0;
            end
            else
                pix_out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_out_ch.valid && pix_out_ch.ready)
            sb.check_result({pix_out_ch.red, pix_out_ch.green, pix_out_ch.blue});
    end

    task automatic send_pixel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                              logic [CHAN_W-1:0] c);
        pix_in_ch.valid  <= 1'b1;
        pix_in_ch.chan_a <= a;
        pix_in_ch.chan_b <= b;
        pix_in_ch.chan_c <= c;
        do
            @(posedge clk);
        while (!pix_in_ch.ready);
        sb.note_request(a, b, c);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic drain_pixels();
        pix_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        drain_pixels();
        repeat (PIPE_DEPTH + 3) @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        mode_we    <= 1'b0;
        sb.set_mode(m);
    endtask

    // Mostly uniform, with a bias toward the edges of the range and the chroma midpoint.
    function automatic logic [CHAN_W-1:0] pick_chan();
        logic [CHAN_W-1:0] edges[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 6)];
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [MODE_W-1:0] phase_modes[8];
        logic [CHAN_W-1:0] h;
        logic [CHAN_W-1:0] s;
        phase_modes      = '{csrgb_pkg::MODE_HSV, csrgb_pkg::MODE_YCC, csrgb_pkg::MODE_RGB,
                             csrgb_pkg::MODE_HSV, MODE_SPARE, csrgb_pkg::MODE_YCC,
                             csrgb_pkg::MODE_HSV, csrgb_pkg::MODE_YCC};
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        mode_we          <= 1'b0;
        mode_wdata       <= csrgb_pkg::MODE_RGB;
        pix_in_ch.valid  <= 1'b0;
        pix_in_ch.chan_a <= '0;
        pix_in_ch.chan_b <= '0;
        pix_in_ch.chan_c <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through straight out of reset.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'hAA, 8'h55, 8'hA5);

        write_mode(csrgb_pkg::MODE_YCC);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);

        write_mode(csrgb_pkg::MODE_HSV);
        send_pixel(8'd17, 8'd0, 8'd200);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd200, 8'd100);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd42, 8'd255, 8'd255);
        send_pixel(8'd43, 8'd255, 8'd255);
        send_pixel(8'd85, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd255, 8'd255);
        send_pixel(8'd213, 8'd128, 8'd255);
        send_pixel(8'd100, 8'd1, 8'd0);

        write_mode(MODE_SPARE);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd255, 8'd0, 8'd128);

        for (int ph = 0; ph < 8; ph++)
        begin
            // The closing phase runs at full rate on both sides.
            if (ph == 7)
                idle_on = 1'b0;
            write_mode(phase_modes[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ((ph == 2 && i == PHASE_ITEMS / 2)
                    || (idle_on && $urandom_range(0, 199) == 0))
                    drain_pixels();
                h = pick_chan();
                s = pick_chan();
                if (phase_modes[ph] == csrgb_pkg::MODE_HSV && $urandom_range(0, 15) == 0)
                    s = 8'd0;
                send_pixel(h, s, pick_chan());
            end
        end

        drain_pixels();
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (sb.pending_rgb.size() != 0)
        begin
            $display("%0t: %0d results expected, actual none", $time, sb.pending_rgb.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("color_space_to_rgb_unit regression: pass");
        else
            $display("color_space_to_rgb_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/csrgb_pkg.sv
rtl/core/csrgb_in_if.sv
rtl/core/csrgb_out_if.sv
rtl/core/csrgb_const_div.sv
rtl/core/color_space_to_rgb_unit.sv
test/tb_color_space_to_rgb_unit.sv
